FILE: hw/rtl/m3i_pkg.sv
// shared widths, types and the cofactor index table for the 3x3 inverse
`timescale 1ns / 1ps

package m3i_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NELEM      = 9;

    localparam int PW     = 2 * ELEM_WIDTH;          // element product
    localparam int CW     = PW + 1;                  // signed cofactor
    localparam int CMW    = PW;                      // cofactor magnitude
    localparam int HIW    = CW - ELEM_WIDTH;         // upper cofactor slice
    localparam int DW     = 3 * ELEM_WIDTH + 3;      // signed determinant
    localparam int DMW    = DW - 1;                  // determinant magnitude
    localparam int SH     = 2 * FRAC_BITS;           // numerator scale
    localparam int NUMW   = CMW + SH;                // scaled numerator
    localparam int RW0    = NUMW - ELEM_WIDTH;       // initial remainder
    localparam int DATA_W = NELEM * ELEM_WIDTH;
    localparam int USER_W = 2;

    localparam int USER_SINGULAR = 0;
    localparam int USER_OVERFLOW = 1;

    typedef logic [3:0] idx_t;

    // cofactor k = e[a]*e[b] - e[c]*e[d], k = col*3+row of the inverse
    localparam idx_t COF_TAB [NELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic                                 sing;
        logic [NELEM-1:0]                     neg;
        logic [NELEM-1:0]                     sat;
        logic [DMW-1:0]                       dmag;
        logic [NELEM-1:0][DMW-1:0]            rem;
        logic [NELEM-1:0][ELEM_WIDTH-1:0]     qr;
    } div_t;

endpackage

FILE: hw/rtl/m3i_det.sv
// cofactors and determinant, five register stages
`timescale 1ns / 1ps

module m3i_det
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic [m3i_pkg::DATA_W-1:0]             in_data,
    output logic                                   out_vld,
    output logic signed [m3i_pkg::CW-1:0]          cof [m3i_pkg::NELEM],
    output logic signed [m3i_pkg::DW-1:0]          det
);

    logic [4:0] vld_reg;

    logic signed [m3i_pkg::ELEM_WIDTH-1:0] e_reg [m3i_pkg::NELEM];
    logic signed [m3i_pkg::PW-1:0]         prod_reg [m3i_pkg::NELEM][2];
    logic signed [m3i_pkg::PW-1:0]         prod_next [m3i_pkg::NELEM][2];
    logic signed [m3i_pkg::ELEM_WIDTH-1:0] eb_reg [3];
    logic signed [m3i_pkg::ELEM_WIDTH-1:0] ec_reg [3];
    logic signed [m3i_pkg::CW-1:0]         cof_reg [m3i_pkg::NELEM];
    logic signed [m3i_pkg::CW-1:0]         cof_next [m3i_pkg::NELEM];
    logic signed [m3i_pkg::CW-1:0]         cofd_reg [m3i_pkg::NELEM];
    logic signed [m3i_pkg::CW-1:0]         cofe_reg [m3i_pkg::NELEM];
    logic signed [m3i_pkg::CW-1:0]         lo_reg [3];
    logic signed [m3i_pkg::CW-1:0]         lo_next [3];
    logic signed [m3i_pkg::CW-1:0]         hi_reg [3];
    logic signed [m3i_pkg::CW-1:0]         hi_next [3];
    logic signed [m3i_pkg::DW-1:0]         det_reg;
    logic signed [m3i_pkg::DW-1:0]         det_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_comb
    begin
        for (int k = 0; k < m3i_pkg::NELEM; k++)
        begin
            prod_next[k][0] = e_reg[m3i_pkg::COF_TAB[k][0]] * e_reg[m3i_pkg::COF_TAB[k][1]];
            prod_next[k][1] = e_reg[m3i_pkg::COF_TAB[k][2]] * e_reg[m3i_pkg::COF_TAB[k][3]];
            cof_next[k]     = prod_reg[k][0] - prod_reg[k][1];
        end
    end

    // cofactor split into unsigned low and signed high slice for the det products
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lo_next[j] = ec_reg[j]
                * $signed({1'b0, cof_reg[j][m3i_pkg::ELEM_WIDTH-1:0]});
            hi_next[j] = ec_reg[j]
                * $signed(cof_reg[j][m3i_pkg::CW-1:m3i_pkg::ELEM_WIDTH]);
        end
    end

    always_comb
    begin
        logic signed [m3i_pkg::DW-1:0] acc;
        logic signed [m3i_pkg::DW-1:0] th;
        logic signed [m3i_pkg::DW-1:0] tl;
        acc = '0;
        for (int j = 0; j < 3; j++)
        begin
            th  = hi_reg[j];
            tl  = lo_reg[j];
            acc = acc + (th <<< m3i_pkg::ELEM_WIDTH) + tl;
        end
        det_next = acc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3i_pkg::NELEM; k++)
            begin
                e_reg[k]       <= $signed(in_data[k*m3i_pkg::ELEM_WIDTH +: m3i_pkg::ELEM_WIDTH]);
                prod_reg[k][0] <= prod_next[k][0];
                prod_reg[k][1] <= prod_next[k][1];
                cof_reg[k]     <= cof_next[k];
                cofd_reg[k]    <= cof_reg[k];
                cofe_reg[k]    <= cofd_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                eb_reg[j] <= e_reg[3*j];
                ec_reg[j] <= eb_reg[j];
                lo_reg[j] <= lo_next[j];
                hi_reg[j] <= hi_next[j];
            end
            det_reg <= det_next;
        end
    end

    assign out_vld = vld_reg[4];
    assign cof     = cofe_reg;
    assign det     = det_reg;

endmodule

FILE: hw/rtl/m3i_prep.sv
// magnitudes, signs, singular and early saturation check, divider setup
`timescale 1ns / 1ps

module m3i_prep
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic signed [m3i_pkg::CW-1:0]          cof [m3i_pkg::NELEM],
    input  logic signed [m3i_pkg::DW-1:0]          det,
    output logic                                   out_vld,
    output m3i_pkg::div_t                          out_div
);

    logic [1:0] vld_reg;

    logic [m3i_pkg::CMW-1:0]   cmag_reg [m3i_pkg::NELEM];
    logic [m3i_pkg::CMW-1:0]   cmag_next [m3i_pkg::NELEM];
    logic [m3i_pkg::NELEM-1:0] neg_reg;
    logic [m3i_pkg::NELEM-1:0] neg_next;
    logic [m3i_pkg::DMW-1:0]   dmag_reg;
    logic [m3i_pkg::DMW-1:0]   dmag_next;
    logic                      sing_reg;
    m3i_pkg::div_t             div_reg;
    m3i_pkg::div_t             div_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_vld};
        end
    end

    always_comb
    begin
        logic signed [m3i_pkg::CW-1:0] ca;
        logic signed [m3i_pkg::DW-1:0] da;
        da        = det[m3i_pkg::DW-1] ? -det : det;
        dmag_next = da[m3i_pkg::DMW-1:0];
        for (int k = 0; k < m3i_pkg::NELEM; k++)
        begin
            ca           = cof[k][m3i_pkg::CW-1] ? -cof[k] : cof[k];
            cmag_next[k] = ca[m3i_pkg::CMW-1:0];
            neg_next[k]  = cof[k][m3i_pkg::CW-1] ^ det[m3i_pkg::DW-1];
        end
    end

    // quotient bits that fit the element only when the top part is below |det|
    always_comb
    begin
        logic [m3i_pkg::NUMW-1:0] num;
        logic [m3i_pkg::DMW-1:0]  rem0;
        div_next.sing = sing_reg;
        div_next.neg  = neg_reg;
        div_next.dmag = dmag_reg;
        for (int k = 0; k < m3i_pkg::NELEM; k++)
        begin
            num  = {cmag_reg[k], {m3i_pkg::SH{1'b0}}};
            rem0 = m3i_pkg::DMW'(num[m3i_pkg::NUMW-1:m3i_pkg::ELEM_WIDTH]);
            div_next.sat[k] = rem0 >= dmag_reg;
            div_next.rem[k] = rem0;
            div_next.qr[k]  = num[m3i_pkg::ELEM_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmag_reg <= cmag_next;
            neg_reg  <= neg_next;
            dmag_reg <= dmag_next;
            sing_reg <= (det == '0);
            div_reg  <= div_next;
        end
    end

    assign out_vld = vld_reg[1];
    assign out_div = div_reg;

endmodule

FILE: hw/rtl/m3i_div_stage.sv
// one restoring division step for all nine lanes
`timescale 1ns / 1ps

module m3i_div_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  m3i_pkg::div_t     in_div,
    output logic              out_vld,
    output m3i_pkg::div_t     out_div
);

    logic          vld_reg;
    m3i_pkg::div_t div_reg;
    m3i_pkg::div_t div_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    // qr shifts numerator bits out at the top and quotient bits in at the bottom
    always_comb
    begin
        logic [m3i_pkg::DMW:0] t;
        logic [m3i_pkg::DMW:0] d;
        logic                  qb;
        div_next = in_div;
        d        = {1'b0, in_div.dmag};
        for (int k = 0; k < m3i_pkg::NELEM; k++)
        begin
            t  = {in_div.rem[k], in_div.qr[k][m3i_pkg::ELEM_WIDTH-1]};
            qb = (t >= d);
            if (qb)
            begin
                t = t - d;
            end
            div_next.rem[k] = t[m3i_pkg::DMW-1:0];
            div_next.qr[k]  = {in_div.qr[k][m3i_pkg::ELEM_WIDTH-2:0], qb};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_div = div_reg;

endmodule

FILE: hw/rtl/m3i_round.sv
// round half away from zero, saturate, apply sign, zero singular results, output register
`timescale 1ns / 1ps

module m3i_round
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  m3i_pkg::div_t                     in_div,
    output logic                              out_vld,
    output logic [m3i_pkg::DATA_W-1:0]        out_data,
    output logic [m3i_pkg::USER_W-1:0]        out_user
);

    localparam int EW = m3i_pkg::ELEM_WIDTH;

    logic                       vld1_reg;
    logic                       vld2_reg;
    logic [EW:0]                q_reg [m3i_pkg::NELEM];
    logic [EW:0]                q_next [m3i_pkg::NELEM];
    logic [m3i_pkg::NELEM-1:0]  ovf_reg;
    logic [m3i_pkg::NELEM-1:0]  ovf_next;
    logic [m3i_pkg::NELEM-1:0]  neg_reg;
    logic                       sing_reg;
    logic [m3i_pkg::DATA_W-1:0] data_reg;
    logic [m3i_pkg::DATA_W-1:0] data_next;
    logic [m3i_pkg::USER_W-1:0] user_reg;
    logic [m3i_pkg::USER_W-1:0] user_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_comb
    begin
        logic [m3i_pkg::DMW:0] r2;
        logic                  up;
        for (int k = 0; k < m3i_pkg::NELEM; k++)
        begin
            r2        = {in_div.rem[k], 1'b0};
            up        = (r2 >= {1'b0, in_div.dmag});
            q_next[k] = {1'b0, in_div.qr[k]} + {{EW{1'b0}}, up};
            if (in_div.neg[k])
            begin
                ovf_next[k] = in_div.sat[k] || (q_next[k] > {2'b01, {(EW-1){1'b0}}});
            end
            else
            begin
                ovf_next[k] = in_div.sat[k] || (q_next[k] > {2'b00, {(EW-1){1'b1}}});
            end
        end
    end

    always_comb
    begin
        logic [EW:0]   nq;
        logic [EW-1:0] v;
        for (int k = 0; k < m3i_pkg::NELEM; k++)
        begin
            nq = -q_reg[k];
            if (sing_reg)
            begin
                v = '0;
            end
            else if (ovf_reg[k])
            begin
                v = neg_reg[k] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
            end
            else
            begin
                v = neg_reg[k] ? nq[EW-1:0] : q_reg[k][EW-1:0];
            end
            data_next[k*EW +: EW] = v;
        end
        user_next                         = '0;
        user_next[m3i_pkg::USER_SINGULAR] = sing_reg;
        user_next[m3i_pkg::USER_OVERFLOW] = !sing_reg && (|ovf_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg    <= q_next;
            ovf_reg  <= ovf_next;
            neg_reg  <= in_div.neg;
            sing_reg <= in_div.sing;
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign out_vld  = vld2_reg;
    assign out_data = data_reg;
    assign out_user = user_reg;

endmodule

FILE: hw/rtl/matrix3_inverse.sv
// 3x3 matrix inverse in signed Q16.16, fully pipelined
// 41 register stages (5 det, 2 setup, 32 division steps, 2 round)
// throughput: one matrix per cycle unless a result waits with m_axis_tready low
// the whole pipeline holds while a result waits and m_axis_tready is low
// reset clears only the valid bits; no item is in flight after reset
`timescale 1ns / 1ps

module matrix3_inverse
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // in_col0_row0, in_col0_row1, ... in_col2_row2, 32 bits each
    input  logic [m3i_pkg::DATA_W-1:0]         s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_col0_row0, out_col0_row1, ... out_col2_row2, 32 bits each
    output logic [m3i_pkg::DATA_W-1:0]         m_axis_tdata,
    // singular, overflow
    output logic [m3i_pkg::USER_W-1:0]         m_axis_tuser
);

    logic                          adv;
    logic                          det_vld;
    logic signed [m3i_pkg::CW-1:0] cof [m3i_pkg::NELEM];
    logic signed [m3i_pkg::DW-1:0] det;
    logic                          dvld [m3i_pkg::ELEM_WIDTH+1];
    m3i_pkg::div_t                 dchain [m3i_pkg::ELEM_WIDTH+1];

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    m3i_det u_det
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s_axis_tvalid),
        .in_data (s_axis_tdata),
        .out_vld (det_vld),
        .cof     (cof),
        .det     (det)
    );

    m3i_prep u_prep
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (det_vld),
        .cof     (cof),
        .det     (det),
        .out_vld (dvld[0]),
        .out_div (dchain[0])
    );

    for (genvar i = 0; i < m3i_pkg::ELEM_WIDTH; i++)
    begin : g_div
        m3i_div_stage u_stage
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (dvld[i]),
            .in_div  (dchain[i]),
            .out_vld (dvld[i+1]),
            .out_div (dchain[i+1])
        );
    end

    m3i_round u_round
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (dvld[m3i_pkg::ELEM_WIDTH]),
        .in_div   (dchain[m3i_pkg::ELEM_WIDTH]),
        .out_vld  (m_axis_tvalid),
        .out_data (m_axis_tdata),
        .out_user (m_axis_tuser)
    );

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[m3i_pkg::USER_SINGULAR] |-> m_axis_tdata == '0)
        else $error("singular result with nonzero data");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[m3i_pkg::USER_SINGULAR]
                            && m_axis_tuser[m3i_pkg::USER_OVERFLOW]))
        else $error("singular and overflow both set");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(dvld[m3i_pkg::ELEM_WIDTH]))
        else $error("division pipe moved during stall");

endmodule

FILE: tb/sv/tb_matrix3_inverse.sv
// self-checking testbench for the 3x3 fixed-point matrix inverse
`timescale 1ns / 1ps

module tb_matrix3_inverse;

    typedef logic signed [199:0] wide_t;
    typedef logic [199:0] uwide_t;

    typedef struct {
        logic [m3i_pkg::DATA_W-1:0] elems;
        logic [m3i_pkg::USER_W-1:0] flags;
    } inverse_t;

    // keeps the expected inverses in arrival order and compares results
    class inverse_scoreboard;
        inverse_t pending[$];
        int errors;
        int checked;
        int singular_seen;
        int overflow_seen;

        function new();
            errors = 0;
            checked = 0;
            singular_seen = 0;
            overflow_seen = 0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
            errors++;
        endtask

        // exact cofactors and determinant, then one rounding per element
        function inverse_t predict_inverse(logic [m3i_pkg::DATA_W-1:0] m);
            inverse_t r;
            wide_t e [m3i_pkg::NELEM];
            wide_t cof [m3i_pkg::NELEM];
            wide_t det;
            wide_t num;
            uwide_t mag;
            uwide_t mdet;
            uwide_t q;
            logic neg;
            logic ovf;
            for (int k = 0; k < m3i_pkg::NELEM; k++)
                e[k] = wide_t'($signed(m[k*m3i_pkg::ELEM_WIDTH +: m3i_pkg::ELEM_WIDTH]));
            for (int k = 0; k < m3i_pkg::NELEM; k++)
                cof[k] = e[m3i_pkg::COF_TAB[k][0]] * e[m3i_pkg::COF_TAB[k][1]]
                       - e[m3i_pkg::COF_TAB[k][2]] * e[m3i_pkg::COF_TAB[k][3]];
            det = e[0] * cof[0] + e[3] * cof[1] + e[6] * cof[2];
            r.elems = '0;
            r.flags = '0;
            if (det == 0)
            begin
                r.flags[m3i_pkg::USER_SINGULAR] = 1'b1;
                return r;
            end
            ovf = 1'b0;
            mdet = (det < 0) ? uwide_t'(-det) : uwide_t'(det);
            for (int k = 0; k < m3i_pkg::NELEM; k++)
            begin
                num = cof[k] <<< m3i_pkg::SH;
                neg = (num < 0) != (det < 0);
                mag = (num < 0) ? uwide_t'(-num) : uwide_t'(num);
                // nearest, ties away from zero
                q = (2 * mag + mdet) / (2 * mdet);
                if (!neg && q > uwide_t'((64'd1 << (m3i_pkg::ELEM_WIDTH - 1)) - 1))
                begin
                    q = uwide_t'((64'd1 << (m3i_pkg::ELEM_WIDTH - 1)) - 1);
                    ovf = 1'b1;
                end
                if (neg && q > uwide_t'(64'd1 << (m3i_pkg::ELEM_WIDTH - 1)))
                begin
                    q = uwide_t'(64'd1 << (m3i_pkg::ELEM_WIDTH - 1));
                    ovf = 1'b1;
                end
                if (neg)
                    q = -q;
                r.elems[k*m3i_pkg::ELEM_WIDTH +: m3i_pkg::ELEM_WIDTH] =
                    q[m3i_pkg::ELEM_WIDTH-1:0];
            end
            r.flags[m3i_pkg::USER_OVERFLOW] = ovf;
            return r;
        endfunction

        function void note_matrix(logic [m3i_pkg::DATA_W-1:0] m);
            pending.push_back(predict_inverse(m));
        endfunction

        task check_inverse(logic [m3i_pkg::DATA_W-1:0] d, logic [m3i_pkg::USER_W-1:0] u);
            inverse_t want;
            checked++;
            if (u[m3i_pkg::USER_SINGULAR]) singular_seen++;
            if (u[m3i_pkg::USER_OVERFLOW]) overflow_seen++;
            if (pending.size() == 0)
            begin
                report("unexpected result", d[63:0], 64'd0);
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < m3i_pkg::NELEM; k++)
                if (d[k*m3i_pkg::ELEM_WIDTH +: m3i_pkg::ELEM_WIDTH]
                    !== want.elems[k*m3i_pkg::ELEM_WIDTH +: m3i_pkg::ELEM_WIDTH])
                    report($sformatf("out_col%0d_row%0d", k / 3, k % 3),
                           64'(d[k*m3i_pkg::ELEM_WIDTH +: m3i_pkg::ELEM_WIDTH]),
                           64'(want.elems[k*m3i_pkg::ELEM_WIDTH +: m3i_pkg::ELEM_WIDTH]));
            if (u[m3i_pkg::USER_SINGULAR] !== want.flags[m3i_pkg::USER_SINGULAR])
                report("singular", 64'(u[m3i_pkg::USER_SINGULAR]),
                       64'(want.flags[m3i_pkg::USER_SINGULAR]));
            if (u[m3i_pkg::USER_OVERFLOW] !== want.flags[m3i_pkg::USER_OVERFLOW])
                report("overflow", 64'(u[m3i_pkg::USER_OVERFLOW]),
                       64'(want.flags[m3i_pkg::USER_OVERFLOW]));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [m3i_pkg::DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [m3i_pkg::DATA_W-1:0] m_axis_tdata;
    logic [m3i_pkg::USER_W-1:0] m_axis_tuser;

    inverse_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int sent;
    longint cycles;

    matrix3_inverse dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_inverse(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // caller stands at a rising edge; returns at the edge the item was taken, or after the idle gap that may follow it
    task automatic send_matrix(logic [m3i_pkg::DATA_W-1:0] m);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= m;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_matrix(m);
        sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom};
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic logic [m3i_pkg::DATA_W-1:0] pack9(logic [31:0] a0, logic [31:0] a1,
        logic [31:0] a2, logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
        logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
        return {c2, c1, c0, b2, b1, b0, a2, a1, a0};
    endfunction

    function automatic logic [31:0] small_elem();
        return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    function automatic logic [m3i_pkg::DATA_W-1:0] random_matrix();
        logic [m3i_pkg::DATA_W-1:0] m;
        int kind;
        kind = $urandom_range(9);
        for (int k = 0; k < m3i_pkg::NELEM; k++)
            m[k*32 +: 32] = (kind < 4) ? $urandom : small_elem();
        if (kind == 8)
            m[2*96-1 -: 96] = m[95:0];          // repeated column: singular
        else if (kind == 9)
            for (int k = 0; k < m3i_pkg::NELEM; k++)
                if (k % 4 != 0)
                    m[k*32 +: 32] = ($urandom_range(3) == 0) ? small_elem() : 32'd0;
        return m;
    endfunction

    task automatic run_directed();
        send_matrix(pack9(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
        send_matrix(pack9(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
        send_matrix('0);
        send_matrix({m3i_pkg::NELEM{32'h7FFF_FFFF}});
        send_matrix({m3i_pkg::NELEM{32'h8000_0000}});
        send_matrix({m3i_pkg::NELEM{32'hFFFF_FFFF}});
        send_matrix(pack9(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF));
        send_matrix(pack9(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000));
        // tiny diagonal makes the inverse saturate both ways
        send_matrix(pack9(1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1));
        // one third on the diagonal exercises rounding
        send_matrix(pack9(3 * ONE_Q, 0, 0, 0, 3 * ONE_Q, 0, 0, 0, 3 * ONE_Q));
        send_matrix(pack9(2, 0, 0, 0, 2, 0, 0, 0, 2));
        send_matrix(pack9(3, 0, 0, 0, ONE_Q, 0, 0, 0, -3));
        send_matrix({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555});
        send_matrix(pack9(0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0));
        send_matrix(pack9(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q,
                          6 * ONE_Q, 7 * ONE_Q, 8 * ONE_Q, 9 * ONE_Q));
        send_matrix(pack9(2 * ONE_Q, -ONE_Q, 0, -ONE_Q, 2 * ONE_Q, -ONE_Q,
                          0, -ONE_Q, 2 * ONE_Q));
        send_matrix(pack9(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, ONE_Q, 32'h7FFF_FFFF,
                          ONE_Q, 0, 32'h8000_0000));
        send_matrix(pack9(4 * ONE_Q, 0, 0, 0, 0, 0, 0, 0, ONE_Q));
        for (int i = 0; i < 4; i++)
            send_matrix(random_matrix());
    endtask

    initial
    begin
        sb = new();
        sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int i = 0; i < 200; i++)
                send_matrix(random_matrix());
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("sent %0d matrices, checked %0d inverses", sent, sb.checked);
        $display("singular results %0d, saturated results %0d, mismatches %0d",
                 sb.singular_seen, sb.overflow_seen, sb.errors);
        if (sb.errors == 0 && sb.checked == sent)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: matrix3_inverse.f
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_det.sv
hw/rtl/m3i_prep.sv
hw/rtl/m3i_div_stage.sv
hw/rtl/m3i_round.sv
hw/rtl/matrix3_inverse.sv
tb/sv/tb_matrix3_inverse.sv
